// File: rtl/core/base64_stream_decoder_unit_macros.svh
// Assertion macros for the Base64 stream decoder.
// Both macros sample on the rising edge of clock and are disabled in reset.
`ifndef BASE64_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64_STREAM_DECODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define B64_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("b64dec assertion failed");

// Next-cycle implication
`define B64_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("b64dec assertion failed");

`else

`define B64_ASSERT_IMP(lbl, ante, cons)
`define B64_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/b64dec_pkg.sv
package b64dec_pkg;

   localparam int BYTE_W  = 8;
   localparam int SYM_W   = 6;
   localparam int ACCUM_W = 18;
   localparam int MAX_RES = 3;

   // decoder phase: symbols held, pad seen, padding complete, error
   typedef enum logic [2:0] {
      PH_SYM0  = 3'd0,
      PH_SYM1  = 3'd1,
      PH_SYM2  = 3'd2,
      PH_SYM3  = 3'd3,
      PH_PAD1  = 3'd4,
      PH_DONE  = 3'd5,
      PH_ERROR = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      SYM_DATA = 2'd0,
      SYM_PAD  = 2'd1,
      SYM_SKIP = 2'd2
   } sym_kind_type;

   typedef struct packed {
      sym_kind_type       kind;
      logic [SYM_W-1:0]   value;
   } sym_type;

   // one group of results handed from the decoder to the output stage
   typedef struct packed {
      logic [MAX_RES-1:0][BYTE_W-1:0] bytes;       // bytes[0] goes out first
      logic [1:0]                     byte_count;  // decoded bytes, 0..3
      logic [1:0]                     last_idx;    // index of the final result
      logic                           bad;
      logic                           done;
   } group_type;

   // character codes
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   localparam logic [7:0]       LOWER_OFS = 8'd26;
   localparam logic [7:0]       DIGIT_OFS = 8'd52;
   localparam logic [SYM_W-1:0] SYM_62    = 6'd62;
   localparam logic [SYM_W-1:0] SYM_63    = 6'd63;

   // alphabet lookup
   function automatic sym_type sym_lookup(input logic [7:0] c, input logic url_alphabet);
      sym_type s;
      s.kind  = SYM_SKIP;
      s.value = '0;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         s.kind  = SYM_DATA;
         s.value = SYM_W'(c - CH_UPPER_A);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         s.kind  = SYM_DATA;
         s.value = SYM_W'(c - CH_LOWER_A + LOWER_OFS);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         s.kind  = SYM_DATA;
         s.value = SYM_W'(c - CH_ZERO + DIGIT_OFS);
      end else if (c == CH_EQUAL) begin
         s.kind  = SYM_PAD;
      end else if (url_alphabet) begin
         if (c == CH_MINUS) begin
            s.kind  = SYM_DATA;
            s.value = SYM_62;
         end else if (c == CH_UNDER) begin
            s.kind  = SYM_DATA;
            s.value = SYM_63;
         end
      end else begin
         if (c == CH_PLUS) begin
            s.kind  = SYM_DATA;
            s.value = SYM_62;
         end else if (c == CH_SLASH) begin
            s.kind  = SYM_DATA;
            s.value = SYM_63;
         end
      end
      return s;
   endfunction

endpackage

// File: rtl/core/b64dec_decode.sv
module b64dec_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  url_alphabet,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_char_valid,
   input  logic [7:0]            in_char,
   input  logic                  in_eom,
   output logic                  grp_valid,
   input  logic                  grp_ready,
   output b64dec_pkg::group_type grp
);
   import b64dec_pkg::*;

   logic                 hold_valid_ff, hold_valid_in;
   logic                 char_valid_ff;
   logic [7:0]           char_ff;
   logic                 eom_ff;
   phase_type            phase_ff, phase_in;
   logic [ACCUM_W-1:0]   accum_ff, accum_in;

   sym_type              sym;
   phase_type            ph_mid, ph_end;
   logic [ACCUM_W-1:0]   acc_mid;
   logic [SYM_W*4-1:0]   full_group;
   logic [1:0]           nbytes;
   logic                 has_result;
   logic                 advance;

   assign sym        = sym_lookup(char_ff, url_alphabet);
   assign full_group = {accum_ff, sym.value};

   // character step, then end-of-message check and flush
   always_comb begin
      ph_mid    = phase_ff;
      acc_mid   = accum_ff;
      grp.bytes = '0;
      nbytes    = 2'd0;
      if (char_valid_ff && sym.kind != SYM_SKIP) begin
         case (phase_ff)
            PH_SYM0: begin
               if (sym.kind == SYM_DATA) begin
                  acc_mid = {accum_ff[ACCUM_W-SYM_W-1:0], sym.value};
                  ph_mid  = PH_SYM1;
               end else begin
                  ph_mid  = PH_ERROR;
               end
            end
            PH_SYM1: begin
               if (sym.kind == SYM_DATA) begin
                  acc_mid = {accum_ff[ACCUM_W-SYM_W-1:0], sym.value};
                  ph_mid  = PH_SYM2;
               end else begin
                  ph_mid  = PH_ERROR;
               end
            end
            PH_SYM2: begin
               if (sym.kind == SYM_DATA) begin
                  acc_mid = {accum_ff[ACCUM_W-SYM_W-1:0], sym.value};
                  ph_mid  = PH_SYM3;
               end else begin
                  grp.bytes[0] = accum_ff[11:4];
                  nbytes       = 2'd1;
                  ph_mid       = PH_PAD1;
               end
            end
            PH_SYM3: begin
               if (sym.kind == SYM_DATA) begin
                  grp.bytes[0] = full_group[23:16];
                  grp.bytes[1] = full_group[15:8];
                  grp.bytes[2] = full_group[7:0];
                  nbytes       = 2'd3;
                  acc_mid      = '0;
                  ph_mid       = PH_SYM0;
               end else begin
                  grp.bytes[0] = accum_ff[17:10];
                  grp.bytes[1] = accum_ff[9:2];
                  nbytes       = 2'd2;
                  ph_mid       = PH_DONE;
               end
            end
            PH_PAD1: begin
               ph_mid = (sym.kind == SYM_PAD) ? PH_DONE : PH_ERROR;
            end
            PH_DONE: begin
               ph_mid = PH_ERROR;
            end
            default: begin
               ph_mid = phase_ff;
            end
         endcase
      end

      // end check: a partial group with no pending bytes flushes here
      ph_end = ph_mid;
      if (eom_ff) begin
         case (ph_mid)
            PH_SYM1, PH_PAD1: begin
               ph_end = PH_ERROR;
            end
            PH_SYM2: begin
               grp.bytes[0] = acc_mid[11:4];
               nbytes       = 2'd1;
            end
            PH_SYM3: begin
               grp.bytes[0] = acc_mid[17:10];
               grp.bytes[1] = acc_mid[9:2];
               nbytes       = 2'd2;
            end
            default: begin
               ph_end = ph_mid;
            end
         endcase
      end

      grp.byte_count = nbytes;
      grp.last_idx   = (nbytes == 2'd0) ? 2'd0 : nbytes - 2'd1;
      grp.bad        = (ph_end >= PH_ERROR);
      grp.done       = eom_ff;
   end

   // hand-off and hold-register control
   assign has_result = (nbytes != 2'd0) || eom_ff;
   assign grp_valid  = hold_valid_ff && has_result;
   assign advance    = hold_valid_ff && (!has_result || grp_ready);
   assign in_ready   = !hold_valid_ff || advance;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (in_valid && in_ready) begin
         hold_valid_in = 1'b1;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end
      phase_in = phase_ff;
      accum_in = accum_ff;
      if (advance) begin
         phase_in = eom_ff ? PH_SYM0 : ph_end;
         accum_in = eom_ff ? '0 : acc_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= PH_SYM0;
         accum_ff      <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         accum_ff      <= accum_in;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         char_valid_ff <= in_char_valid;
         char_ff       <= in_char;
         eom_ff        <= in_eom;
      end
   end

endmodule

// File: rtl/core/b64dec_serial.sv
module b64dec_serial (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  grp_valid,
   output logic                  grp_ready,
   input  b64dec_pkg::group_type grp,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast
);
   import b64dec_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   group_type  grp_ff;
   logic       is_last;
   logic       take;
   logic       data_vld;

   assign is_last   = (idx_ff == grp_ff.last_idx);
   assign take      = valid_ff && rsp_tready;
   assign grp_ready = !valid_ff || (take && is_last);

   // group register and result index
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (grp_valid && grp_ready) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (take) begin
         if (is_last) begin
            valid_in = 1'b0;
         end
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp_valid && grp_ready) begin
         grp_ff <= grp;
      end
   end

   // result fields; a status-only result carries a zero byte
   assign data_vld   = (idx_ff < grp_ff.byte_count);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_vld ? grp_ff.bytes[idx_ff] : '0;
   assign rsp_tuser  = {grp_ff.done, grp_ff.bad, data_vld};
   assign rsp_tlast  = is_last;

endmodule

// File: rtl/core/base64_stream_decoder_unit.sv
// Channel   Dir  tdata           tuser                                    tlast
// req_      in   char_in [7:0]   char_valid                               end_of_message
// rsp_      out  data_byte [7:0] data_valid, bad_input, message_done      last_of_run
// csr_      in   url_alphabet    -                                        -
//
// An item is held in the hold register and decodes on the way to the result register.
// Items that give no result go through at one per cycle; an item with results holds the input
// until the result register takes its group; results leave one per cycle while rsp_tready
// is high. Synchronous active-high reset clears the decoder phase, the accumulator and both
// valid flags; there is no clearing pass. A stall on rsp_tready backs up into req_tready.
`include "base64_stream_decoder_unit_macros.svh"

module base64_stream_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tuser,   // [0] char_valid
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [2:0] rsp_tuser,   // [0] data_valid, [1] bad_input, [2] message_done
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import b64dec_pkg::*;

   logic      url_alphabet_ff, url_alphabet_in;
   logic      grp_valid;
   logic      grp_ready;
   group_type grp;

   // alphabet select register
   assign url_alphabet_in = csr_wr_en ? csr_wr_data : url_alphabet_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         url_alphabet_ff <= 1'b0;
      end else begin
         url_alphabet_ff <= url_alphabet_in;
      end
   end

   b64dec_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .url_alphabet  (url_alphabet_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_char_valid (req_tuser),
      .in_char       (req_tdata),
      .in_eom        (req_tlast),
      .grp_valid     (grp_valid),
      .grp_ready     (grp_ready),
      .grp           (grp)
   );

   b64dec_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .grp_valid  (grp_valid),
      .grp_ready  (grp_ready),
      .grp        (grp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a result without a byte is only the closing status of a message
   `B64_ASSERT_IMP(a_status_only_closes, rsp_tvalid && !rsp_tuser[0], rsp_tuser[2] && rsp_tlast)
   // a status result carries a zero byte
   `B64_ASSERT_IMP(a_status_zero_byte, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 8'h00)
   // results of one item follow each other without a gap
   `B64_ASSERT_NEXT(a_group_no_gap, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)

endmodule

// File: verif/base64_stream_decoder_checker.sv
// Watches the character and result streams of the Base64 decoder, keeps its own
// decoder state, and compares every result transaction with the oldest prediction.
module base64_stream_decoder_checker
   import b64dec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [2:0] rsp_tuser,
   input  logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output int         pending,
   output int         fail_count
);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       data_valid;
      logic       bad_input;
      logic       message_done;
      logic       last_of_run;
   } decoded_t;

   decoded_t    decoded_q[$];
   phase_type   dec_phase;
   logic [17:0] group_bits;
   logic        alphabet_url;

   // map one character to a symbol under the selected alphabet
   function automatic sym_type classify(input logic [7:0] c, input logic url);
      sym_type s;
      s.kind  = SYM_SKIP;
      s.value = '0;
      if (c >= "A" && c <= "Z") begin
         s.kind  = SYM_DATA;
         s.value = 6'(c - "A");
      end else if (c >= "a" && c <= "z") begin
         s.kind  = SYM_DATA;
         s.value = 6'(c - "a" + 8'd26);
      end else if (c >= "0" && c <= "9") begin
         s.kind  = SYM_DATA;
         s.value = 6'(c - "0" + 8'd52);
      end else if (c == "=") begin
         s.kind = SYM_PAD;
      end else if ((url && c == "-") || (!url && c == "+")) begin
         s.kind  = SYM_DATA;
         s.value = 6'd62;
      end else if ((url && c == "_") || (!url && c == "/")) begin
         s.kind  = SYM_DATA;
         s.value = 6'd63;
      end
      return s;
   endfunction

   // advance the decoder by one input transaction and queue the results it causes
   task automatic decode_item(input logic has_char, input logic [7:0] c, input logic eom);
      logic [2:0][7:0] out_bytes;
      logic [23:0]     full;
      sym_type         s;
      decoded_t        r;
      int              n;
      int              count;
      logic            bad;
      n         = 0;
      out_bytes = '0;
      if (has_char) begin
         s = classify(c, alphabet_url);
         if (dec_phase < PH_ERROR && s.kind != SYM_SKIP) begin
            case (dec_phase)
               PH_SYM0, PH_SYM1: begin
                  if (s.kind == SYM_DATA) begin
                     group_bits = {group_bits[11:0], s.value};
                     dec_phase  = (dec_phase == PH_SYM0) ? PH_SYM1 : PH_SYM2;
                  end else begin
                     dec_phase = PH_ERROR;
                  end
               end
               PH_SYM2: begin
                  if (s.kind == SYM_DATA) begin
                     group_bits = {group_bits[11:0], s.value};
                     dec_phase  = PH_SYM3;
                  end else begin
                     out_bytes[n] = group_bits[11:4];
                     n++;
                     dec_phase = PH_PAD1;
                  end
               end
               PH_SYM3: begin
                  if (s.kind == SYM_DATA) begin
                     full         = {group_bits, s.value};
                     out_bytes[0] = full[23:16];
                     out_bytes[1] = full[15:8];
                     out_bytes[2] = full[7:0];
                     n            = 3;
                     group_bits   = '0;
                     dec_phase    = PH_SYM0;
                  end else begin
                     out_bytes[0] = group_bits[17:10];
                     out_bytes[1] = group_bits[9:2];
                     n            = 2;
                     dec_phase    = PH_DONE;
                  end
               end
               PH_PAD1: dec_phase = (s.kind == SYM_PAD) ? PH_DONE : PH_ERROR;
               default: dec_phase = PH_ERROR;
            endcase
         end
      end

      // end check and flush of a partial group
      if (eom) begin
         if (dec_phase == PH_SYM1 || dec_phase == PH_PAD1) begin
            dec_phase = PH_ERROR;
         end else if (dec_phase == PH_SYM2) begin
            out_bytes[n] = group_bits[11:4];
            n++;
         end else if (dec_phase == PH_SYM3) begin
            out_bytes[n] = group_bits[17:10];
            out_bytes[n + 1] = group_bits[9:2];
            n += 2;
         end
      end

      bad   = (dec_phase >= PH_ERROR);
      count = (eom && n == 0) ? 1 : n;
      for (int k = 0; k < count; k++) begin
         r.data_byte    = (k < n) ? out_bytes[k] : 8'h00;
         r.data_valid   = (k < n);
         r.bad_input    = bad;
         r.message_done = eom;
         r.last_of_run  = (k == count - 1);
         decoded_q.push_back(r);
      end

      if (eom) begin
         dec_phase  = PH_SYM0;
         group_bits = '0;
      end
   endtask

   function automatic int field_mismatch(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   initial begin
      fail_count   = 0;
      pending      = 0;
      dec_phase    = PH_SYM0;
      group_bits   = '0;
      alphabet_url = 1'b0;
   end

   always @(posedge clock) begin
      decoded_t want;
      if (reset) begin
         dec_phase    = PH_SYM0;
         group_bits   = '0;
         alphabet_url = 1'b0;
         decoded_q.delete();
      end else begin
         if (csr_wr_en)
            alphabet_url = csr_wr_data;

         // result transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected result transaction: data_byte %0h tuser %0b tlast %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = decoded_q.pop_front();
               fail_count += field_mismatch("data_byte", want.data_byte, rsp_tdata);
               fail_count += field_mismatch("data_valid", 8'(want.data_valid),
                                            8'(rsp_tuser[0]));
               fail_count += field_mismatch("bad_input", 8'(want.bad_input),
                                            8'(rsp_tuser[1]));
               fail_count += field_mismatch("message_done", 8'(want.message_done),
                                            8'(rsp_tuser[2]));
               fail_count += field_mismatch("last_of_run", 8'(want.last_of_run),
                                            8'(rsp_tlast));
            end
         end

         if (req_tvalid && req_tready)
            decode_item(req_tuser, req_tdata, req_tlast);
      end
      pending = decoded_q.size();
   end

endmodule

// File: verif/tb_base64_stream_decoder_unit.sv
// Stimulus and verdict for the Base64 stream decoder; checking lives in the checker.
module tb_base64_stream_decoder_unit;
   import b64dec_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS   = 50;
   localparam int RANDOM_PHASES = 6;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] char_in
   logic       req_tuser;    // [0] char_valid
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] data_byte
   logic [2:0] rsp_tuser;    // [0] data_valid, [1] bad_input, [2] message_done
   logic       rsp_tlast;
   logic       csr_wr_en;
   logic       csr_wr_data;

   int          pending;
   int          fail_count;
   int unsigned items_sent;
   int unsigned cycles;
   logic        url_mode;
   logic        calm;

   base64_stream_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   base64_stream_decoder_checker decode_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_base64_stream_decoder_unit NOT OK");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] sym_char(input int unsigned v, input logic url);
      if (v < 26) return 8'(v) + "A";
      if (v < 52) return 8'(v - 26) + "a";
      if (v < 62) return 8'(v - 52) + "0";
      if (v == 62) return url ? "-" : "+";
      return url ? "_" : "/";
   endfunction

   // characters that fall outside the selected alphabet
   function automatic logic [7:0] noise_char(input logic url);
      case ($urandom_range(0, 5))
         0:       return " ";
         1:       return 8'h0A;
         2:       return ".";
         3:       return url ? "+" : "-";
         4:       return url ? "/" : "_";
         default: return 8'($urandom_range(128, 255));
      endcase
   endfunction

   // result side backpressure
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(30, 80)) @(negedge clock);
         else
            repeat ($urandom_range(1, 12)) @(negedge clock);
         stall = calm ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // one character transaction, then an optional gap
   task automatic send_item(input logic has_char, input logic [7:0] c, input logic eom);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= has_char;
      req_tdata  <= c;
      req_tlast  <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (has_char || eom) items_sent++;
      @(negedge clock);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_text(input string s, input logic eom_last);
      for (int i = 0; i < s.len(); i++)
         send_item(1'b1, s[i], eom_last && (i == s.len() - 1));
   endtask

   task automatic send_end();
      send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
   endtask

   // hold off the sender until every predicted result is out and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_alphabet(input logic url);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= url;
      url_mode     = url;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly well-formed messages with random symbols; some random junk
   task automatic send_random_message();
      logic [7:0]  msg[$];
      int unsigned shape;
      int unsigned groups;
      int unsigned tail;
      int unsigned pads;
      int unsigned len;
      logic        close_on_char;
      shape = $urandom_range(0, 99);
      if (shape < 78) begin
         groups = $urandom_range(0, 2);
         tail   = $urandom_range(0, 2);
         pads   = 0;
         repeat (groups * 4) msg.push_back(sym_char($urandom_range(0, 63), url_mode));
         if (tail == 1) begin
            repeat (2) msg.push_back(sym_char($urandom_range(0, 63), url_mode));
            pads = $urandom_range(0, 2);   // a single pad here is a bad ending
         end else if (tail == 2) begin
            repeat (3) msg.push_back(sym_char($urandom_range(0, 63), url_mode));
            pads = $urandom_range(0, 1);
         end
         repeat (pads) msg.push_back(CH_EQUAL);
      end else begin
         len = $urandom_range(1, 8);
         repeat (len) begin
            case ($urandom_range(0, 3))
               0, 1:    msg.push_back(sym_char($urandom_range(0, 63), url_mode));
               2:       msg.push_back(CH_EQUAL);
               default: msg.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end

      close_on_char = ($urandom_range(0, 1) == 1) && (msg.size() > 0);
      foreach (msg[i]) begin
         if ($urandom_range(0, 99) < 8)
            send_item(1'b1, noise_char(url_mode), 1'b0);
         if ($urandom_range(0, 99) < 5)
            send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
         send_item(1'b1, msg[i], close_on_char && (i == msg.size() - 1));
      end
      if (!close_on_char)
         send_end();
   endtask

   initial begin
      int unsigned phase_start;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      items_sent  = 0;
      url_mode    = 1'b0;
      calm        = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: standard alphabet
      write_alphabet(1'b0);
      send_text("A/z9", 1'b0);       // alphabet extremes, full group
      send_text("Z0a+", 1'b1);       // full group closing the message
      send_text("QUI=", 1'b0);       // one pad after three symbols
      send_end();
      send_text("QQ==Q", 1'b1);      // data after padding
      send_text("=", 1'b1);          // pad with no symbols
      send_text("Q", 1'b1);          // single leftover symbol
      send_text("QQ=", 1'b1);        // second pad missing

      // directed: URL-safe alphabet, skipped character, flush of two bytes at the end
      write_alphabet(1'b1);
      send_text("-_.A", 1'b1);

      // random phases, alternating alphabets, one phase without idling
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_alphabet(ph % 2 == 0);
         calm        = (ph == 3);
         phase_start = items_sent;
         while (items_sent < phase_start + PHASE_ITEMS)
            send_random_message();
      end
      calm = 1'b0;

      settle();
      if (fail_count == 0 && pending == 0)
         $display("tb_base64_stream_decoder_unit OK");
      else
         $display("tb_base64_stream_decoder_unit NOT OK");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/b64dec_pkg.sv
rtl/core/b64dec_decode.sv
rtl/core/b64dec_serial.sv
rtl/core/base64_stream_decoder_unit.sv
verif/base64_stream_decoder_checker.sv
verif/tb_base64_stream_decoder_unit.sv
